// ===== sv/triangle_texel_rasterizer_unit_assert.svh =====
// assertion macros for the triangle texel rasterizer checker
`ifndef TRIANGLE_TEXEL_RASTERIZER_UNIT_ASSERT_SVH
`define TRIANGLE_TEXEL_RASTERIZER_UNIT_ASSERT_SVH

// property checked outside reset
`define TTR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ttr assertion failed");

// property checked on every edge, reset included
`define TTR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ttr assertion failed");

`endif

// ===== sv/ttr_pkg.sv =====
// ----------------------------------------------------------------------------
// ttr_pkg
// shared constants, types and helpers of the triangle texel rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package ttr_pkg;

  localparam int MAX_SIDE      = 64;
  localparam int COORD_ENTRIES = 1024;
  localparam int FRACTION_BITS = 16;

  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W   = $clog2(CELLS);
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int ENTRY_W  = $clog2(COORD_ENTRIES);
  localparam int COORD_W  = 18;
  localparam int RES_W    = 7;
  localparam int FACE_W   = 16;
  localparam int WEIGHT_W = 18;
  localparam int TEXEL_W  = 12;
  localparam int CMD_W    = 2;

  // scaled corner, corner difference, area product, area sum
  localparam int POS_W  = COORD_W + RES_W + 1;
  localparam int DIFF_W = POS_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NUM_W  = PROD_W + 1;

  // quotient: three integer bits and the fraction
  localparam int QUOT_W = FRACTION_BITS + 3;
  localparam int WQ_W   = QUOT_W + 1;
  localparam int W2_W   = WQ_W + 2;
  localparam int BND_W  = POS_W - FRACTION_BITS + 2;

  localparam int TOLERANCE = ((1 << FRACTION_BITS) + 5000) / 10000;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
  } coord_entry_t;

  typedef struct packed {
    logic                       valid;
    logic [FACE_W-1:0]          face;
    logic signed [WEIGHT_W-1:0] wa;
    logic signed [WEIGHT_W-1:0] wb;
    logic signed [WEIGHT_W-1:0] wc;
  } store_entry_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    store_entry_t      data;
  } store_wr_t;

  function automatic logic signed [WEIGHT_W-1:0] sat_weight(input logic signed [W2_W-1:0] w);
    logic signed [W2_W-1:0] hi;
    logic signed [W2_W-1:0] lo;
    hi = W2_W'((1 << (WEIGHT_W - 1)) - 1);
    lo = -W2_W'(1 << (WEIGHT_W - 1));
    if (w > hi) begin
      return hi[WEIGHT_W-1:0];
    end else if (w < lo) begin
      return lo[WEIGHT_W-1:0];
    end
    return w[WEIGHT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/ttr_ifs.sv =====
// ----------------------------------------------------------------------------
// ttr channel interfaces
// command, result and configuration channels with valid / ready
// ----------------------------------------------------------------------------
`default_nettype none

interface ttr_req_if;
  import ttr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [ENTRY_W-1:0]        entry_index;
  logic signed [COORD_W-1:0] coord_u;
  logic signed [COORD_W-1:0] coord_v;
  logic [ENTRY_W-1:0]        corner_a;
  logic [ENTRY_W-1:0]        corner_b;
  logic [ENTRY_W-1:0]        corner_c;
  logic [FACE_W-1:0]         face_tag;
  logic [TEXEL_W-1:0]        texel_index;
  modport source (output valid, cmd, entry_index, coord_u, coord_v, corner_a, corner_b,
                  corner_c, face_tag, texel_index, input ready);
  modport sink (input valid, cmd, entry_index, coord_u, coord_v, corner_a, corner_b,
                corner_c, face_tag, texel_index, output ready);
endinterface

interface ttr_rsp_if;
  import ttr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       covered;
  logic [FACE_W-1:0]          face_found;
  logic signed [WEIGHT_W-1:0] weight_a;
  logic signed [WEIGHT_W-1:0] weight_b;
  logic signed [WEIGHT_W-1:0] weight_c;
  logic                       degenerate;
  modport source (output valid, covered, face_found, weight_a, weight_b, weight_c,
                  degenerate, input ready);
  modport sink (input valid, covered, face_found, weight_a, weight_b, weight_c,
                degenerate, output ready);
endinterface

interface ttr_cfg_if;
  import ttr_pkg::*;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/ttr_coord_mem.sv =====
// ----------------------------------------------------------------------------
// ttr_coord_mem
// vertex coordinate table, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_coord_mem (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ttr_pkg::ENTRY_W-1:0] waddr,
  input  wire ttr_pkg::coord_entry_t wdata,
  input  wire logic [ttr_pkg::ENTRY_W-1:0] raddr,
  output ttr_pkg::coord_entry_t      rdata
);
  import ttr_pkg::*;

  coord_entry_t mem [COORD_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/ttr_texel_store.sv =====
// ----------------------------------------------------------------------------
// ttr_texel_store
// per-texel face and weight memory with a clearing sweep
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_texel_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ttr_pkg::store_wr_t        wr,
  input  wire logic                      clr_start,
  output logic                           clr_busy,
  input  wire logic [ttr_pkg::CELL_W-1:0] raddr,
  output ttr_pkg::store_entry_t          rdata
);
  import ttr_pkg::*;

  store_entry_t      mem [CELLS];
  logic [CELL_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_start) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == CELL_W'(CELLS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/ttr_divider.sv =====
// ----------------------------------------------------------------------------
// ttr_divider
// signed fixed-point divide, one quotient bit per cycle, saturating at 8
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [ttr_pkg::NUM_W-1:0] num,
  input  wire logic signed [ttr_pkg::NUM_W-1:0] den,
  output logic                                  busy,
  output logic signed [ttr_pkg::WQ_W-1:0]       quot
);
  import ttr_pkg::*;

  localparam int REM_W = NUM_W + 3;
  localparam int CNT_W = $clog2(QUOT_W);

  logic [REM_W-1:0]  rem;
  logic [NUM_W-1:0]  ud;
  logic [QUOT_W-1:0] q;
  logic              neg;
  logic              chk;
  logic [CNT_W-1:0]  cnt;

  logic [NUM_W-1:0] un_in;
  logic [NUM_W-1:0] ud_in;
  logic [REM_W-1:0] dd;
  logic [REM_W-1:0] d8;

  assign un_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign ud_in = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
  assign dd    = {1'b0, ud, 2'b00};
  assign d8    = {ud, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk  <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      chk  <= 1'b1;
      cnt  <= '0;
    end else if (busy && chk) begin
      // integer part of 8 or more saturates
      if (rem >= d8) begin
        busy <= 1'b0;
      end
      chk <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(QUOT_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= REM_W'(un_in);
      ud  <= ud_in;
      neg <= num[NUM_W-1] ^ den[NUM_W-1];
      q   <= '0;
    end else if (busy && chk) begin
      if (rem >= d8) begin
        q <= '1;
      end
    end else if (busy) begin
      if (rem >= dd) begin
        rem <= REM_W'((rem - dd) << 1);
        q   <= {q[QUOT_W-2:0], 1'b1};
      end else begin
        rem <= REM_W'(rem << 1);
        q   <= {q[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign quot = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

`default_nettype wire

// ===== sv/triangle_texel_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_texel_rasterizer_unit
// vertex table plus texel store, rasterizes triangles by barycentric weights
// ----------------------------------------------------------------------------
// Each command word yields one result word. A load passes through the accept
// and the result stage, and a read also through a read stage for the read
// latency of the texel store. A clear sweeps the texel store one entry a
// cycle, and the same sweep runs after reset before the first command word is
// taken. A draw runs a setup (three table reads, determinant, bounding box)
// and then visits each texel of the clamped bounding box, waiting at each for
// the two radix-2 dividers that make 19 quotient bits each. A degenerate or
// empty triangle ends after setup. The result register lets the next command
// word be taken while a result word still waits.
`default_nettype none

module triangle_texel_rasterizer_unit (
  input wire logic  clk,
  input wire logic  rst,
  ttr_req_if.sink   req,
  ttr_rsp_if.source rsp,
  ttr_cfg_if.sink   cfg
);
  import ttr_pkg::*;

  // sequencer codes
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_C0   = 4'd2;
  localparam logic [3:0] S_C1   = 4'd3;
  localparam logic [3:0] S_C2   = 4'd4;
  localparam logic [3:0] S_DET1 = 4'd5;
  localparam logic [3:0] S_DET2 = 4'd6;
  localparam logic [3:0] S_DET3 = 4'd7;
  localparam logic [3:0] S_PIX  = 4'd8;
  localparam logic [3:0] S_SUM  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_WB   = 4'd11;
  localparam logic [3:0] S_RD   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  // configuration
  logic [RES_W-1:0] resolution;
  logic [RES_W-1:0] side;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RES_W'(MAX_SIDE);
    end else if (cfg.valid) begin
      resolution <= cfg.data;
    end
  end

  // 0 acts as 1, above the grid acts as the full grid
  always_comb begin
    if (resolution == '0) begin
      side = RES_W'(1);
    end else if (resolution > RES_W'(MAX_SIDE)) begin
      side = RES_W'(MAX_SIDE);
    end else begin
      side = resolution;
    end
  end

  logic accept;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // held command fields
  logic [ENTRY_W-1:0] corner_b;
  logic [ENTRY_W-1:0] corner_c;
  logic [FACE_W-1:0]  face;
  logic [TEXEL_W-1:0] texel;
  logic               clr_cmd;

  // pending result word
  logic                       p_covered;
  logic [FACE_W-1:0]          p_face;
  logic signed [WEIGHT_W-1:0] p_wa;
  logic signed [WEIGHT_W-1:0] p_wb;
  logic signed [WEIGHT_W-1:0] p_wc;
  logic                       p_degen;

  // coordinate table
  logic [ENTRY_W-1:0] c_raddr;
  coord_entry_t       c_rdata;
  coord_entry_t       c_wdata;

  assign c_wdata.u = req.coord_u;
  assign c_wdata.v = req.coord_v;

  always_comb begin
    case (state)
      S_C0:    c_raddr = corner_b;
      S_C1:    c_raddr = corner_c;
      default: c_raddr = req.corner_a;
    endcase
  end

  ttr_coord_mem u_coord (
    .clk   (clk),
    .we    (accept && (req.cmd == CMD_LOAD)),
    .waddr (req.entry_index),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // texel store
  store_wr_t         s_wr;
  logic              clr_busy;
  logic [CELL_W-1:0] s_raddr;
  store_entry_t      s_rdata;

  assign s_raddr = req.texel_index[CELL_W-1:0];

  ttr_texel_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr        (s_wr),
    .clr_start (accept && (req.cmd == CMD_CLEAR)),
    .clr_busy  (clr_busy),
    .raddr     (s_raddr),
    .rdata     (s_rdata)
  );

  // scaled corners
  logic signed [POS_W-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [POS_W-1:0] sx;
  logic signed [POS_W-1:0] sy;

  assign sx = POS_W'(c_rdata.u * $signed({1'b0, side}));
  assign sy = POS_W'(c_rdata.v * $signed({1'b0, side}));

  // edge terms
  logic signed [DIFF_W-1:0] ea, eb, ec, ed, ee;
  assign ea = DIFF_W'(y1) - DIFF_W'(y2);
  assign eb = DIFF_W'(x2) - DIFF_W'(x1);
  assign ec = DIFF_W'(y2) - DIFF_W'(y0);
  assign ed = DIFF_W'(x0) - DIFF_W'(x2);
  assign ee = DIFF_W'(y0) - DIFF_W'(y2);

  // texel centre relative to the third corner
  logic [SIDE_W-1:0]        col;
  logic [SIDE_W-1:0]        row;
  logic signed [DIFF_W-1:0] px;
  logic signed [DIFF_W-1:0] py;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;

  assign px = $signed({{(DIFF_W - SIDE_W - FRACTION_BITS){1'b0}}, col, 1'b1,
                       {(FRACTION_BITS - 1){1'b0}}});
  assign py = $signed({{(DIFF_W - SIDE_W - FRACTION_BITS){1'b0}}, row, 1'b1,
                       {(FRACTION_BITS - 1){1'b0}}});
  assign dx = px - DIFF_W'(x2);
  assign dy = py - DIFF_W'(y2);

  // area products; m0 and m1 are shared by the determinant and the texel pass
  logic signed [PROD_W-1:0] m0, m1, m2, m3;
  logic signed [NUM_W-1:0]  denom;
  logic signed [NUM_W-1:0]  n0;
  logic signed [NUM_W-1:0]  n1;

  assign n0 = NUM_W'(m0) + NUM_W'(m1);
  assign n1 = NUM_W'(m2) + NUM_W'(m3);

  always_ff @(posedge clk) begin
    if (state == S_DET1) begin
      m0 <= ea * ed;
      m1 <= eb * ee;
    end else if (state == S_PIX) begin
      m0 <= ea * dx;
      m1 <= eb * dy;
      m2 <= ec * dx;
      m3 <= ed * dy;
    end
  end

  // bounding box
  logic signed [POS_W-1:0] xmin, xmax, ymin, ymax;
  logic signed [BND_W-1:0] bx_lo, bx_hi, by_lo, by_hi;
  logic signed [BND_W-1:0] cl, ch, rl, rh;
  logic signed [BND_W-1:0] lim;
  logic [SIDE_W-1:0]       c_lo, c_hi, r_hi;

  always_comb begin
    xmin = (x0 < x1) ? x0 : x1;
    xmin = (xmin < x2) ? xmin : x2;
    xmax = (x0 > x1) ? x0 : x1;
    xmax = (xmax > x2) ? xmax : x2;
    ymin = (y0 < y1) ? y0 : y1;
    ymin = (ymin < y2) ? ymin : y2;
    ymax = (y0 > y1) ? y0 : y1;
    ymax = (ymax > y2) ? ymax : y2;
  end

  // clamp to the grid
  assign lim = BND_W'(side) - BND_W'(1);
  assign cl  = (bx_lo < 0) ? '0 : bx_lo;
  assign rl  = (by_lo < 0) ? '0 : by_lo;
  assign ch  = (bx_hi > lim) ? lim : bx_hi;
  assign rh  = (by_hi > lim) ? lim : by_hi;

  // dividers, one per computed weight
  logic                   div_start;
  logic                   busy_a;
  logic                   busy_b;
  logic signed [WQ_W-1:0] q_a;
  logic signed [WQ_W-1:0] q_b;

  assign div_start = (state == S_SUM);

  ttr_divider u_div_a (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (n0),
    .den   (denom),
    .busy  (busy_a),
    .quot  (q_a)
  );

  ttr_divider u_div_b (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (n1),
    .den   (denom),
    .busy  (busy_b),
    .quot  (q_b)
  );

  // third weight and coverage test
  logic signed [W2_W-1:0] w0, w1, w2;
  logic                   hit;
  logic [2*RES_W-1:0]     t_full;

  assign w0  = W2_W'(q_a);
  assign w1  = W2_W'(q_b);
  assign w2  = W2_W'(1 << FRACTION_BITS) - w0 - w1;
  assign hit = (w0 >= -W2_W'(TOLERANCE)) && (w1 >= -W2_W'(TOLERANCE)) &&
               (w2 >= -W2_W'(TOLERANCE));
  assign t_full = (2*RES_W)'(row) * (2*RES_W)'(side) + (2*RES_W)'(col);

  always_comb begin
    s_wr.en          = (state == S_WB) && hit;
    s_wr.addr        = t_full[CELL_W-1:0];
    s_wr.data.valid  = 1'b1;
    s_wr.data.face   = face;
    s_wr.data.wa     = sat_weight(w0);
    s_wr.data.wb     = sat_weight(w1);
    s_wr.data.wc     = sat_weight(w2);
  end

  // readback limit is side squared
  logic [2*RES_W-1:0] t_lim;
  logic               in_grid;
  assign t_lim   = (2*RES_W)'(side) * (2*RES_W)'(side);
  assign in_grid = ((2*RES_W)'(texel) < t_lim);

  logic out_free;
  assign out_free = !rsp.valid || rsp.ready;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLR: begin
        if (!clr_busy) begin
          state_next = clr_cmd ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            CMD_LOAD:  state_next = S_FIN;
            CMD_DRAW:  state_next = S_C0;
            CMD_READ:  state_next = S_RD;
            CMD_CLEAR: state_next = S_CLR;
            default:   state_next = S_FIN;
          endcase
        end
      end
      S_C0:   state_next = S_C1;
      S_C1:   state_next = S_C2;
      S_C2:   state_next = S_DET1;
      S_DET1: state_next = S_DET2;
      S_DET2: state_next = S_DET3;
      S_DET3: begin
        if ((denom == '0) || (cl > ch) || (rl > rh)) begin
          state_next = S_FIN;
        end else begin
          state_next = S_PIX;
        end
      end
      S_PIX:  state_next = S_SUM;
      S_SUM:  state_next = S_DIV;
      S_DIV: begin
        if (!busy_a && !busy_b) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        if ((col == c_hi) && (row == r_hi)) begin
          state_next = S_FIN;
        end else begin
          state_next = S_PIX;
        end
      end
      S_RD:  state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cmd <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        clr_cmd <= (req.cmd == CMD_CLEAR);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      corner_b  <= req.corner_b;
      corner_c  <= req.corner_c;
      face      <= req.face_tag;
      texel     <= req.texel_index;
      p_covered <= 1'b0;
      p_face    <= '0;
      p_wa      <= '0;
      p_wb      <= '0;
      p_wc      <= '0;
      p_degen   <= 1'b0;
    end
    case (state)
      S_C0: begin
        x0 <= sx;
        y0 <= sy;
      end
      S_C1: begin
        x1 <= sx;
        y1 <= sy;
      end
      S_C2: begin
        x2 <= sx;
        y2 <= sy;
      end
      S_DET2: begin
        denom <= n0;
        bx_lo <= BND_W'(xmin >>> FRACTION_BITS);
        by_lo <= BND_W'(ymin >>> FRACTION_BITS);
        bx_hi <= BND_W'(((POS_W + 1)'(xmax) + (POS_W + 1)'((1 << FRACTION_BITS) - 1))
                        >>> FRACTION_BITS);
        by_hi <= BND_W'(((POS_W + 1)'(ymax) + (POS_W + 1)'((1 << FRACTION_BITS) - 1))
                        >>> FRACTION_BITS);
      end
      S_DET3: begin
        p_degen <= (denom == '0);
        c_lo    <= cl[SIDE_W-1:0];
        c_hi    <= ch[SIDE_W-1:0];
        r_hi    <= rh[SIDE_W-1:0];
        col     <= cl[SIDE_W-1:0];
        row     <= rl[SIDE_W-1:0];
      end
      S_WB: begin
        // raster order: columns inside rows
        if (col == c_hi) begin
          col <= c_lo;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      S_RD: begin
        if (s_rdata.valid && in_grid) begin
          p_covered <= 1'b1;
          p_face    <= s_rdata.face;
          p_wa      <= s_rdata.wa;
          p_wb      <= s_rdata.wb;
          p_wc      <= s_rdata.wc;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      rsp.covered    <= p_covered;
      rsp.face_found <= p_face;
      rsp.weight_a   <= p_wa;
      rsp.weight_b   <= p_wb;
      rsp.weight_c   <= p_wc;
      rsp.degenerate <= p_degen;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ttr_checker.sv =====
// ----------------------------------------------------------------------------
// ttr_checker
// port-level checks on the triangle texel rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_texel_rasterizer_unit_assert.svh"

module ttr_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 req_ready,
  input wire logic                                 rsp_valid,
  input wire logic                                 rsp_ready,
  input wire logic                                 rsp_covered,
  input wire logic [ttr_pkg::FACE_W-1:0]           rsp_face_found,
  input wire logic signed [ttr_pkg::WEIGHT_W-1:0]  rsp_weight_a,
  input wire logic signed [ttr_pkg::WEIGHT_W-1:0]  rsp_weight_b,
  input wire logic signed [ttr_pkg::WEIGHT_W-1:0]  rsp_weight_c,
  input wire logic                                 rsp_degenerate
);
  import ttr_pkg::*;

  // the clearing sweep holds off commands after reset
  `TTR_ASSERT_ALWAYS(a_busy_after_rst, clk, rst |=> !req_ready)

  // a waiting result word stays
  `TTR_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid)

  // a degenerate result never reports a covered texel
  `TTR_ASSERT(a_degen_alone, clk, rst, rsp_valid && rsp_degenerate |-> !rsp_covered)

  // an uncovered word carries no face and no weights
  `TTR_ASSERT(a_uncovered_zero, clk, rst, rsp_valid && !rsp_covered |-> rsp_face_found == '0 && rsp_weight_a == '0 && rsp_weight_b == '0 && rsp_weight_c == '0)

endmodule

bind triangle_texel_rasterizer_unit ttr_checker u_ttr_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_covered    (rsp.covered),
  .rsp_face_found (rsp.face_found),
  .rsp_weight_a   (rsp.weight_a),
  .rsp_weight_b   (rsp.weight_b),
  .rsp_weight_c   (rsp.weight_c),
  .rsp_degenerate (rsp.degenerate)
);

`default_nettype wire
